// File: rtl/mssg_pkg.sv
// Package for the motion session safety gate: payload structs, codes, constants.
// No dependencies.
package mssg_pkg;

    localparam int WHEELS_DEF = 4;
    localparam logic [15:0] LEN_WHEEL = 16'd8;
    localparam logic [15:0] LEN_CALIB = 16'd4;
    localparam logic [31:0] TIMEOUT_RST = 32'd500;

    typedef enum logic [1:0] {
        MODE_BOOT     = 2'd0,
        MODE_DISARMED = 2'd1,
        MODE_ARMED    = 2'd2,
        MODE_FAULT    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        F_NONE     = 3'd0,
        F_SELFTEST = 3'd1,
        F_PROTOCOL = 3'd2,
        F_SESSION  = 3'd3,
        F_SEQUENCE = 3'd4,
        F_TIMEOUT  = 3'd5,
        F_LOCAL    = 3'd6
    } fault_t;

    typedef enum logic [3:0] {
        S_OK           = 4'd0,
        S_BAD_PAYLOAD  = 4'd1,
        S_BAD_STATE    = 4'd2,
        S_BAD_SESSION  = 4'd3,
        S_BAD_SEQUENCE = 4'd4,
        S_HB_REQUIRED  = 4'd5,
        S_SELFTEST_REQ = 4'd6,
        S_MOTION_LOCK  = 4'd7,
        S_REJECTED     = 4'd8,
        S_FAULT_LATCH  = 4'd9,
        S_UNKNOWN      = 4'd10
    } status_t;

    typedef enum logic [3:0] {
        T_STOP      = 4'd0,
        T_DISARM    = 4'd1,
        T_CLEAR     = 4'd2,
        T_HEARTBEAT = 4'd3,
        T_ARM       = 4'd4,
        T_WHEEL     = 4'd5,
        T_CALIB     = 4'd6,
        T_UNKNOWN   = 4'd7,
        T_TICK      = 4'd8,
        T_BOOT_DONE = 4'd9,
        T_LOCAL     = 4'd10,
        T_PROTO     = 4'd11
    } req_type_t;

    typedef enum logic [1:0] {
        DRQ_NONE  = 2'd0,
        DRQ_ARM   = 2'd1,
        DRQ_WHEEL = 2'd2,
        DRQ_CALIB = 2'd3
    } drv_req_t;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_MOTION  = 1'b1;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] pkt_len;
        logic [31:0] session_id_in;
        logic [31:0] sequence_in;
        logic [31:0] now_ms;
        logic [63:0] payload;
        logic        driver_accepts;
        logic        self_test_passed;
        logic [2:0]  local_fault_code;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  ctrl_state;
        logic [2:0]  fault_now;
        logic        motor_zero;
        logic [1:0]  driver_request;
        logic [63:0] driver_payload;
    } out_item_t;

    // Classification made by the front stage.
    typedef struct packed {
        logic is_disarm;   // stop or disarm
        logic is_clear;
        logic is_hb;
        logic is_arm;
        logic is_wheel;
        logic is_calib;
        logic is_tick;
        logic is_boot;
        logic is_local;
        logic is_proto;
        logic is_unknown;
        logic len_zero;
        logic len_wheel;
        logic len_calib;
        logic sid_zero;
        logic seq_zero;
        logic [2:0] local_code;
    } cls_t;

    typedef struct packed {
        cls_t      cls;
        in_item_t  item;
    } qent_t;

endpackage

// File: rtl/mssg_front.sv
// Front stage: accepts items, decodes the type and precomputes item-only checks.
// Depends on mssg_pkg.
module mssg_front import mssg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_valid,
    input  logic     q_ready,
    output qent_t    q_ent
);
    logic  valid_reg, valid_next;
    qent_t ent_reg, ent_next;
    cls_t  c;

    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        c = '0;
        unique case (s_item.req_type)
            T_STOP, T_DISARM: c.is_disarm = 1'b1;
            T_CLEAR:          c.is_clear  = 1'b1;
            T_HEARTBEAT:      c.is_hb     = 1'b1;
            T_ARM:            c.is_arm    = 1'b1;
            T_WHEEL:          c.is_wheel  = 1'b1;
            T_CALIB:          c.is_calib  = 1'b1;
            T_TICK:           c.is_tick   = 1'b1;
            T_BOOT_DONE:      c.is_boot   = 1'b1;
            T_LOCAL:          c.is_local  = 1'b1;
            T_PROTO:          c.is_proto  = 1'b1;
            default:          c.is_unknown = 1'b1;
        endcase
        c.len_zero  = s_item.pkt_len == 16'd0;
        c.len_wheel = s_item.pkt_len == LEN_WHEEL;
        c.len_calib = s_item.pkt_len == LEN_CALIB;
        c.sid_zero  = s_item.session_id_in == 32'd0;
        c.seq_zero  = s_item.sequence_in == 32'd0;
        // code 0 and codes above 6 map to the local fault
        c.local_code = (s_item.local_fault_code == 3'd0 || s_item.local_fault_code == 3'd7)
                       ? F_LOCAL : s_item.local_fault_code;
    end

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            ent_next   = '{cls: c, item: s_item};
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        ent_reg <= ent_next;
    end

    assign q_valid = valid_reg;
    assign q_ent   = ent_reg;
endmodule

// File: rtl/mssg_queue.sv
// Two-entry queue between front and back stages.
// Depends on mssg_pkg.
module mssg_queue import mssg_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  qent_t in_ent,
    output logic  out_valid,
    input  logic  out_ready,
    output qent_t out_ent
);
    qent_t       mem_reg [2];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_ent   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_comb begin
        wp_next  = wr ? ~wp_reg : wp_reg;
        rp_next  = rd ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (wr) begin
            mem_reg[wp_reg] <= in_ent;
        end
    end
endmodule

// File: rtl/mssg_back.sv
// Back stage: holds the session state, applies one item per cycle unless the
// result is stalled, and registers the result. Depends on mssg_pkg.
module mssg_back import mssg_pkg::*; #(
    parameter int WHEELS = WHEELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  qent_t       q_ent,
    input  logic [31:0] timeout_ms,
    input  logic        motion_enabled,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);
    localparam int TW = 16 * WHEELS;

    mode_t       mode_reg, mode_next;
    fault_t      fault_reg, fault_next;
    logic        st_ok_reg, st_ok_next;
    logic        open_reg, open_next;
    logic [31:0] sess_reg, sess_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] hb_reg, hb_next;
    logic [31:0] cmd_reg, cmd_next;
    logic [TW-1:0] tgt_reg, tgt_next;
    logic        ov_reg, ov_next;
    out_item_t   out_reg, out_next;

    cls_t        c;
    in_item_t    it;
    status_t     st;
    logic        zp, drop, go_f, go_d;
    fault_t      fcode;
    drv_req_t    drq;
    logic [63:0] dpl;
    logic        hb_fresh, cmd_fresh, seq_new, sess_match, tz;
    logic        do_item;

    assign q_ready = !ov_reg || m_ready;
    assign do_item = q_valid && q_ready;
    assign c  = q_ent.cls;
    assign it = q_ent.item;

    assign hb_fresh   = (it.now_ms - hb_reg) <= timeout_ms;
    assign cmd_fresh  = (it.now_ms - cmd_reg) <= timeout_ms;
    assign seq_new    = !c.seq_zero && (it.sequence_in > seq_reg);
    assign sess_match = open_reg && (it.session_id_in == sess_reg);
    assign tz         = tgt_reg == '0;

    always_comb begin
        st = S_OK; zp = 1'b0; go_f = 1'b0; go_d = 1'b0; fcode = F_NONE;
        drq = DRQ_NONE; dpl = '0;
        st_ok_next = st_ok_reg;
        open_next = open_reg; sess_next = sess_reg; seq_next = seq_reg;
        hb_next = hb_reg; cmd_next = cmd_reg; tgt_next = tgt_reg;
        mode_next = mode_reg;
        if (c.is_disarm) begin
            if (!c.len_zero) begin go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_PAYLOAD; end
            else go_d = 1'b1;
        end else if (c.is_clear) begin
            zp = 1'b1;
            if (!c.len_zero) st = S_BAD_PAYLOAD;
            else if (mode_reg != MODE_FAULT) st = S_BAD_STATE;
            else if (!st_ok_reg) st = S_SELFTEST_REQ;
            else begin zp = 1'b0; go_d = 1'b1; end
        end else if (c.is_tick) begin
            if (mode_reg == MODE_ARMED && (!hb_fresh || !cmd_fresh)) begin
                go_f = 1'b1; fcode = F_TIMEOUT;
            end
        end else if (c.is_boot) begin
            st_ok_next = it.self_test_passed;
            if (it.self_test_passed) go_d = 1'b1;
            else begin go_f = 1'b1; fcode = F_SELFTEST; end
        end else if (c.is_local) begin
            go_f = 1'b1; fcode = fault_t'(c.local_code);
        end else if (c.is_proto) begin
            go_f = 1'b1; fcode = F_PROTOCOL;
        end else if (mode_reg == MODE_FAULT) begin
            zp = 1'b1; st = S_FAULT_LATCH;
        end else if (c.is_hb) begin
            if (!c.len_zero || c.sid_zero) begin
                go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_PAYLOAD;
            end else if (mode_reg != MODE_DISARMED && mode_reg != MODE_ARMED) begin
                zp = 1'b1; st = S_BAD_STATE;
            end else if (!open_reg) begin
                if (mode_reg != MODE_DISARMED || c.seq_zero) begin
                    go_f = 1'b1; fcode = F_SESSION; st = S_BAD_SESSION;
                end else begin
                    open_next = 1'b1; sess_next = it.session_id_in;
                    seq_next = it.sequence_in; hb_next = it.now_ms;
                end
            end else if (it.session_id_in != sess_reg) begin
                go_f = 1'b1; fcode = F_SESSION; st = S_BAD_SESSION;
            end else if (!seq_new) begin
                go_f = 1'b1; fcode = F_SEQUENCE; st = S_BAD_SEQUENCE;
            end else begin
                seq_next = it.sequence_in; hb_next = it.now_ms;
            end
        end else if (c.is_arm) begin
            if (!c.len_zero) begin go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_PAYLOAD; end
            else if (mode_reg != MODE_DISARMED) begin
                go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_STATE;
            end else if (!st_ok_reg) begin zp = 1'b1; st = S_SELFTEST_REQ; end
            else if (!sess_match) begin go_f = 1'b1; fcode = F_SESSION; st = S_BAD_SESSION; end
            else if (!seq_new) begin go_f = 1'b1; fcode = F_SEQUENCE; st = S_BAD_SEQUENCE; end
            else if (!hb_fresh) begin go_f = 1'b1; fcode = F_TIMEOUT; st = S_HB_REQUIRED; end
            else if (!tz) begin go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_STATE; end
            else begin
                seq_next = it.sequence_in;
                if (!motion_enabled) begin zp = 1'b1; st = S_MOTION_LOCK; end
                else begin
                    drq = DRQ_ARM;
                    if (!it.driver_accepts) begin
                        go_f = 1'b1; fcode = F_LOCAL; st = S_REJECTED;
                    end else begin
                        mode_next = MODE_ARMED; cmd_next = it.now_ms;
                    end
                end
            end
        end else if (c.is_wheel || c.is_calib) begin
            if (c.is_wheel ? !c.len_wheel : !c.len_calib) begin
                go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_PAYLOAD;
            end else if (mode_reg != MODE_ARMED) begin
                go_f = 1'b1; fcode = F_PROTOCOL; st = S_BAD_STATE;
            end else if (!sess_match) begin go_f = 1'b1; fcode = F_SESSION; st = S_BAD_SESSION; end
            else if (!seq_new) begin go_f = 1'b1; fcode = F_SEQUENCE; st = S_BAD_SEQUENCE; end
            else if (!hb_fresh) begin go_f = 1'b1; fcode = F_TIMEOUT; st = S_HB_REQUIRED; end
            else begin
                if (c.is_wheel) begin
                    drq = DRQ_WHEEL;
                    dpl = {{(64-TW){1'b0}}, it.payload[TW-1:0]};
                end else begin
                    drq = DRQ_CALIB;
                    dpl = {32'd0, it.payload[31:0]};
                end
                if (!it.driver_accepts) begin
                    go_f = 1'b1; fcode = F_LOCAL; st = S_REJECTED;
                end else begin
                    if (c.is_wheel) tgt_next = it.payload[TW-1:0];
                    seq_next = it.sequence_in; cmd_next = it.now_ms;
                end
            end
        end else begin
            go_f = 1'b1; fcode = F_PROTOCOL; st = S_UNKNOWN;
        end

        drop = go_f || go_d;
        fault_next = fault_reg;
        if (drop) begin
            zp = 1'b1; open_next = 1'b0; sess_next = '0; seq_next = '0;
            hb_next = '0; cmd_next = '0; tgt_next = '0;
            mode_next  = go_f ? MODE_FAULT : MODE_DISARMED;
            fault_next = go_f ? fcode : F_NONE;
        end
    end

    always_comb begin
        ov_next  = ov_reg;
        out_next = out_reg;
        if (do_item) begin
            ov_next = 1'b1;
            out_next.status         = st;
            out_next.ctrl_state     = mode_next;
            out_next.fault_now      = fault_next;
            out_next.motor_zero     = zp;
            out_next.driver_request = drq;
            out_next.driver_payload = dpl;
        end else if (m_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_BOOT;
            fault_reg <= F_NONE;
            st_ok_reg <= 1'b0;
            open_reg  <= 1'b0;
            sess_reg  <= '0;
            seq_reg   <= '0;
            hb_reg    <= '0;
            cmd_reg   <= '0;
            tgt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            ov_reg <= ov_next;
            if (do_item) begin
                mode_reg  <= mode_next;
                fault_reg <= fault_next;
                st_ok_reg <= st_ok_next;
                open_reg  <= open_next;
                sess_reg  <= sess_next;
                seq_reg   <= seq_next;
                hb_reg    <= hb_next;
                cmd_reg   <= cmd_next;
                tgt_reg   <= tgt_next;
            end
        end
        out_reg <= out_next;
    end

    assign m_valid = ov_reg;
    assign m_item  = out_reg;
endmodule

// File: rtl/motion_session_safety_gate.sv
// Channel   | Ports                          | Carries
// input     | s_valid s_ready s_item         | one command packet or event
// result    | m_valid m_ready m_item         | status, state, fault, driver request
// config    | cfg_valid cfg_ready cfg_index cfg_data | timeout_ms (0), motion_enabled (1)
// One item per cycle sustained while the result output is not stalled; an accepted input
// passes through the front register, the queue and the result register in that order. The
// back stage decides each item from registered state. Synchronous active-low reset
// puts the gate in boot with no session. The queue lets the front accept while a
// result waits.
// Depends on mssg_pkg, mssg_front, mssg_queue, mssg_back.
module motion_session_safety_gate import mssg_pkg::*; #(
    parameter int WHEELS = WHEELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    logic        timeout_wr_unused;
    logic [31:0] timeout_reg;
    logic        motion_reg;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    qent_t       fq_ent, qb_ent;

    assign cfg_ready = 1'b1;
    assign timeout_wr_unused = 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            motion_reg  <= 1'b0;
        end else if (cfg_valid && !timeout_wr_unused) begin
            if (cfg_index == CFG_TIMEOUT) timeout_reg <= cfg_data;
            if (cfg_index == CFG_MOTION)  motion_reg  <= cfg_data[0];
        end
    end

    mssg_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_ent(fq_ent)
    );

    mssg_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_ent(fq_ent),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_ent(qb_ent)
    );

    mssg_back #(.WHEELS(WHEELS)) u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_ent(qb_ent),
        .timeout_ms(timeout_reg), .motion_enabled(motion_reg),
        .m_valid, .m_ready, .m_item
    );
endmodule
